// File: sv/hcc_pkg.sv
// Package for the histogram correlation check core.
// Holds field widths, register indexes, grade codes and sequencer types.
// No dependencies.
package hcc_pkg;

   localparam int BIN_BITS    = 8;
   localparam int COUNT_BITS  = 16;
   localparam int CORR_BITS   = 16;
   localparam int GRADE_BITS  = 2;
   localparam int WEIGHT_BITS = 32;
   localparam int SUM1_BITS   = 40;
   localparam int SUM2_BITS   = 48;
   localparam int FRAC_BITS   = 14;
   localparam int SMUL_BITS   = 16;                 // operand width of the item multiplier
   localparam int SPREAD_BITS = 80;                 // n*sq and s*s products
   localparam int AB_BITS     = 2 * SPREAD_BITS;
   localparam int WIDE_BITS   = 192;                // holds C^2 << (2F+2) and q^2*A*B
   localparam int Q_BITS      = FRAC_BITS + 2;      // search value up to 2^(F+1)
   localparam int BIT_BITS    = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_START = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RANGE_END   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_GREEN_MIN   = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_RED_MIN     = 2'd3;

   localparam logic [GRADE_BITS-1:0] GRADE_GREEN  = 2'd0;
   localparam logic [GRADE_BITS-1:0] GRADE_YELLOW = 2'd1;
   localparam logic [GRADE_BITS-1:0] GRADE_RED    = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ITEM, ST_LOAD, ST_MUL, ST_SUB, ST_TRIAL, ST_ROUND, ST_GRADE
   } state_type;

   typedef enum logic [3:0] {
      J_NSXX, J_SXSX, J_NSYY, J_SYSY, J_AB, J_NSXY, J_SXSY, J_CC, J_LHS
   } job_type;

endpackage

// File: sv/histogram_correlation_check_core.sv
// Histogram correlation check core: weighted sums and Pearson correlation.
// Depends on hcc_pkg.
//
// Usage:
//   Histogram cells arrive on the req_ stream, one transaction per cell; tlast
//   marks the final cell. Cells whose x index lies in the configured range, or
//   every cell when the range start exceeds its end, add their count as a
//   weight to six running sums. After the final cell the core forms the
//   correlation in Q1.14, grades it and offers one rsp_ transaction holding
//   correlation, grade and total entries. Each accepted cell steps one item
//   multiplier through eight products; no new cell is taken until they are
//   done. The final cell then runs the shift-add unit: every wide product
//   consumes one significant multiplier bit per cycle, and the root search
//   runs up to 16 trial products. The shift-add work shrinks when a spread is
//   zero or the sums are small.
//   Configuration goes through the csr_ channel, always ready; write it only
//   while the core is idle.
//   Reset (synchronous, active high) restores register defaults, clears the
//   sums and drops any pending result.
//   When the receiver stalls, the result holds in the output register; the
//   core keeps accepting cells and waits before issuing the next result.
module histogram_correlation_check_core
   import hcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input cells
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [31:0]              req_tdata,   // bin_x[7:0], bin_y[15:8], bin_count[31:16]
   input  logic                     req_tlast,   // last_bin
   // results
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [55:0]              rsp_tdata,   // correlation[15:0], grade[17:16],
                                                 // total_entries[49:18], zero pad
   // configuration writes
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_data
);

   // configuration registers
   logic [BIN_BITS-1:0]         range_start_ff, range_end_ff;
   logic signed [CORR_BITS-1:0] green_min_ff, red_min_ff;

   // sequencer
   state_type state_ff, state_in;
   job_type   job_ff, job_in;
   logic [2:0] phase_ff, phase_in;

   // latched cell
   logic [BIN_BITS-1:0]   x_ff, x_in, y_ff, y_in;
   logic [COUNT_BITS-1:0] w_ff, w_in;
   logic                  last_ff, last_in;
   logic [SMUL_BITS-1:0]  xx_ff, xx_in, xy_ff, xy_in, yy_ff, yy_in;

   // running sums
   logic [WEIGHT_BITS-1:0] sum_w_ff, sum_w_in;
   logic [SUM1_BITS-1:0]   sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic [SUM2_BITS-1:0]   sum_xx_ff, sum_xx_in, sum_yy_ff, sum_yy_in, sum_xy_ff, sum_xy_in;

   // shared shift-add unit and intermediates
   logic [WIDE_BITS-1:0]   acc_ff, acc_in, mcand_ff, mcand_in, rhs_ff, rhs_in;
   logic [SPREAD_BITS-1:0] mplier_ff, mplier_in, p_ff, p_in;
   logic [SPREAD_BITS-1:0] a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [AB_BITS-1:0]     ab_ff, ab_in;
   logic                   neg_ff, neg_in, swap_ff, swap_in;
   logic [Q_BITS-1:0]      q_ff, q_in;
   logic [BIT_BITS-1:0]    bit_ff, bit_in;
   logic signed [CORR_BITS-1:0] corr_ff, corr_in;

   // output register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [CORR_BITS-1:0] rsp_corr_ff, rsp_corr_in;
   logic [GRADE_BITS-1:0]       rsp_grade_ff, rsp_grade_in;
   logic [WEIGHT_BITS-1:0]      rsp_total_ff, rsp_total_in;

   // combinational helpers
   logic [SMUL_BITS-1:0]   m_a, m_b;
   logic [2*SMUL_BITS-1:0] m_prod;
   logic [WIDE_BITS-1:0]   add_a, add_b;
   logic                   add_inv;
   logic [WIDE_BITS:0]     add_sum;
   logic                   add_carry;
   logic [WIDE_BITS-1:0]   add_diff;
   logic [Q_BITS-1:0]      trial;
   logic [Q_BITS:0]        mag_wide;
   logic [CORR_BITS-1:0]   mag;
   logic                   sel;
   logic [BIN_BITS-1:0]    in_x;
   logic [COUNT_BITS-1:0]  in_w;

   assign req_tready = (state_ff == ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_total_ff, rsp_grade_ff, rsp_corr_ff};

   assign in_x = req_tdata[BIN_BITS-1:0];
   assign in_w = req_tdata[31:16];
   assign sel  = (range_start_ff > range_end_ff) ||
                 (in_x >= range_start_ff && in_x <= range_end_ff);

   // the one item multiplier, shared by the sum products and the trial square
   assign m_prod = m_a * m_b;

   // the one wide adder: accumulate during products, subtract or compare otherwise
   assign add_sum   = {1'b0, add_a} + {1'b0, add_b ^ {WIDE_BITS{add_inv}}}
                      + {{WIDE_BITS{1'b0}}, add_inv};
   assign add_carry = add_sum[WIDE_BITS];
   assign add_diff  = add_sum[WIDE_BITS-1:0];

   assign trial    = q_ff | (Q_BITS'(1) << bit_ff);
   assign mag_wide = ({1'b0, q_ff} + (Q_BITS + 1)'(1)) >> 1;
   assign mag      = mag_wide[CORR_BITS-1:0];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         range_start_ff <= 8'd1;
         range_end_ff   <= 8'd0;
         green_min_ff   <= 16'sd14746;
         red_min_ff     <= 16'sd8192;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_START: range_start_ff <= csr_data[BIN_BITS-1:0];
            CSR_RANGE_END:   range_end_ff   <= csr_data[BIN_BITS-1:0];
            CSR_GREEN_MIN:   green_min_ff   <= csr_data;
            CSR_RED_MIN:     red_min_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_ff       <= J_NSXX;
         phase_ff     <= 3'd0;
         rsp_valid_ff <= 1'b0;
         sum_w_ff     <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xx_ff    <= '0;
         sum_yy_ff    <= '0;
         sum_xy_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         job_ff       <= job_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_w_ff     <= sum_w_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         sum_xx_ff    <= sum_xx_in;
         sum_yy_ff    <= sum_yy_in;
         sum_xy_ff    <= sum_xy_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff <= x_in;  y_ff <= y_in;  w_ff <= w_in;  last_ff <= last_in;
      xx_ff <= xx_in;  xy_ff <= xy_in;  yy_ff <= yy_in;
      acc_ff <= acc_in;  mcand_ff <= mcand_in;  mplier_ff <= mplier_in;
      rhs_ff <= rhs_in;  p_ff <= p_in;
      a_ff <= a_in;  b_ff <= b_in;  c_ff <= c_in;  ab_ff <= ab_in;
      neg_ff <= neg_in;  swap_ff <= swap_in;
      q_ff <= q_in;  bit_ff <= bit_in;  corr_ff <= corr_in;
      rsp_corr_ff <= rsp_corr_in;  rsp_grade_ff <= rsp_grade_in;
      rsp_total_ff <= rsp_total_in;
   end

   always_comb begin
      state_in = state_ff;  job_in = job_ff;  phase_in = phase_ff;
      x_in = x_ff;  y_in = y_ff;  w_in = w_ff;  last_in = last_ff;
      xx_in = xx_ff;  xy_in = xy_ff;  yy_in = yy_ff;
      sum_w_in = sum_w_ff;  sum_x_in = sum_x_ff;  sum_y_in = sum_y_ff;
      sum_xx_in = sum_xx_ff;  sum_yy_in = sum_yy_ff;  sum_xy_in = sum_xy_ff;
      acc_in = acc_ff;  mcand_in = mcand_ff;  mplier_in = mplier_ff;
      rhs_in = rhs_ff;  p_in = p_ff;
      a_in = a_ff;  b_in = b_ff;  c_in = c_ff;  ab_in = ab_ff;
      neg_in = neg_ff;  swap_in = swap_ff;
      q_in = q_ff;  bit_in = bit_ff;  corr_in = corr_ff;
      rsp_corr_in = rsp_corr_ff;  rsp_grade_in = rsp_grade_ff;
      rsp_total_in = rsp_total_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      m_a = '0;  m_b = '0;
      add_a = acc_ff;  add_b = '0;  add_inv = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               // zero weight for a cell outside the range leaves the sums alone
               x_in     = in_x;
               y_in     = req_tdata[15:8];
               w_in     = sel ? in_w : '0;
               last_in  = req_tlast;
               phase_in = 3'd0;
               state_in = ST_ITEM;
            end
         end

         ST_ITEM: begin
            phase_in = phase_ff + 3'd1;
            case (phase_ff)
               3'd0: begin
                  m_a = SMUL_BITS'(x_ff);  m_b = SMUL_BITS'(x_ff);
                  xx_in = m_prod[SMUL_BITS-1:0];
               end
               3'd1: begin
                  m_a = SMUL_BITS'(x_ff);  m_b = SMUL_BITS'(y_ff);
                  xy_in = m_prod[SMUL_BITS-1:0];
               end
               3'd2: begin
                  m_a = SMUL_BITS'(y_ff);  m_b = SMUL_BITS'(y_ff);
                  yy_in = m_prod[SMUL_BITS-1:0];
               end
               3'd3: begin
                  m_a = w_ff;  m_b = SMUL_BITS'(x_ff);
                  sum_x_in = sum_x_ff + SUM1_BITS'(m_prod);
               end
               3'd4: begin
                  m_a = w_ff;  m_b = SMUL_BITS'(y_ff);
                  sum_y_in = sum_y_ff + SUM1_BITS'(m_prod);
               end
               3'd5: begin
                  m_a = w_ff;  m_b = xx_ff;
                  sum_xx_in = sum_xx_ff + SUM2_BITS'(m_prod);
               end
               3'd6: begin
                  m_a = w_ff;  m_b = xy_ff;
                  sum_xy_in = sum_xy_ff + SUM2_BITS'(m_prod);
               end
               default: begin
                  m_a = w_ff;  m_b = yy_ff;
                  sum_yy_in = sum_yy_ff + SUM2_BITS'(m_prod);
                  sum_w_in  = sum_w_ff + WEIGHT_BITS'(w_ff);
                  if (last_ff) begin
                     job_in   = J_NSXX;
                     neg_in   = 1'b0;
                     swap_in  = 1'b0;
                     state_in = ST_LOAD;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end

         ST_LOAD: begin
            acc_in   = '0;
            state_in = ST_MUL;
            case (job_ff)
               J_NSXX: begin
                  mcand_in = WIDE_BITS'(sum_xx_ff);  mplier_in = SPREAD_BITS'(sum_w_ff);
               end
               J_SXSX: begin
                  mcand_in = WIDE_BITS'(sum_x_ff);  mplier_in = SPREAD_BITS'(sum_x_ff);
               end
               J_NSYY: begin
                  mcand_in = WIDE_BITS'(sum_yy_ff);  mplier_in = SPREAD_BITS'(sum_w_ff);
               end
               J_SYSY: begin
                  mcand_in = WIDE_BITS'(sum_y_ff);  mplier_in = SPREAD_BITS'(sum_y_ff);
               end
               J_AB: begin
                  mcand_in = WIDE_BITS'(a_ff);  mplier_in = b_ff;
               end
               J_NSXY: begin
                  mcand_in = WIDE_BITS'(sum_xy_ff);  mplier_in = SPREAD_BITS'(sum_w_ff);
               end
               J_SXSY: begin
                  mcand_in = WIDE_BITS'(sum_x_ff);  mplier_in = SPREAD_BITS'(sum_y_ff);
               end
               default: begin
                  mcand_in = WIDE_BITS'(c_ff);  mplier_in = c_ff;
               end
            endcase
         end

         ST_MUL: begin
            if (mplier_ff != '0) begin
               // one multiplier bit per cycle
               add_b     = mplier_ff[0] ? mcand_ff : '0;
               acc_in    = add_diff;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end else begin
               case (job_ff)
                  J_NSXX, J_NSYY, J_NSXY: begin
                     p_in     = acc_ff[SPREAD_BITS-1:0];
                     job_in   = job_type'(job_ff + 4'd1);
                     state_in = ST_LOAD;
                  end
                  J_AB: begin
                     ab_in    = acc_ff[AB_BITS-1:0];
                     job_in   = J_NSXY;
                     state_in = ST_LOAD;
                  end
                  J_CC: begin
                     rhs_in   = acc_ff << (2 * FRAC_BITS + 2);
                     q_in     = '0;
                     bit_in   = BIT_BITS'(Q_BITS - 1);
                     state_in = ST_TRIAL;
                  end
                  default: state_in = ST_SUB;
               endcase
            end
         end

         ST_SUB: begin
            add_inv = 1'b1;
            if (job_ff == J_LHS) begin
               add_a = rhs_ff;
               add_b = acc_ff;
            end else if (swap_ff) begin
               add_a = acc_ff;
               add_b = WIDE_BITS'(p_ff);
            end else begin
               add_a = WIDE_BITS'(p_ff);
               add_b = acc_ff;
            end
            case (job_ff)
               J_SXSX, J_SYSY: begin
                  // a spread that is zero or negative gives a zero correlation
                  if (add_carry && add_diff != '0) begin
                     if (job_ff == J_SXSX) begin
                        a_in   = add_diff[SPREAD_BITS-1:0];
                        job_in = J_NSYY;
                     end else begin
                        b_in   = add_diff[SPREAD_BITS-1:0];
                        job_in = J_AB;
                     end
                     state_in = ST_LOAD;
                  end else begin
                     corr_in  = '0;
                     state_in = ST_GRADE;
                  end
               end
               J_SXSY: begin
                  if (!add_carry && !swap_ff) begin
                     // negative covariance: take the magnitude on the next pass
                     neg_in  = 1'b1;
                     swap_in = 1'b1;
                  end else begin
                     c_in     = add_diff[SPREAD_BITS-1:0];
                     swap_in  = 1'b0;
                     job_in   = J_CC;
                     state_in = ST_LOAD;
                  end
               end
               default: begin
                  // carry set: trial^2 * A*B does not exceed the scaled C^2
                  if (add_carry) q_in = trial;
                  if ((add_carry && bit_ff == BIT_BITS'(Q_BITS - 1)) || bit_ff == '0) begin
                     state_in = ST_ROUND;
                  end else begin
                     bit_in   = bit_ff - BIT_BITS'(1);
                     state_in = ST_TRIAL;
                  end
               end
            endcase
         end

         ST_TRIAL: begin
            m_a       = trial;
            m_b       = trial;
            mcand_in  = WIDE_BITS'(ab_ff);
            mplier_in = SPREAD_BITS'(m_prod);
            acc_in    = '0;
            job_in    = J_LHS;
            state_in  = ST_MUL;
         end

         ST_ROUND: begin
            // drop the guard bit, rounding half away from zero, then apply the sign
            corr_in  = neg_ff ? -$signed(mag) : $signed(mag);
            state_in = ST_GRADE;
         end

         ST_GRADE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_corr_in  = corr_ff;
               rsp_total_in = sum_w_ff;
               if (corr_ff >= green_min_ff)    rsp_grade_in = GRADE_GREEN;
               else if (corr_ff > red_min_ff)  rsp_grade_in = GRADE_YELLOW;
               else                            rsp_grade_in = GRADE_RED;
               sum_w_in  = '0;  sum_x_in  = '0;  sum_y_in  = '0;
               sum_xx_in = '0;  sum_yy_in = '0;  sum_xy_in = '0;
               state_in  = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // the correlation never leaves [-1.0, 1.0]
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_corr_ff <= 16'sd16384 && rsp_corr_ff >= -16'sd16384))
      else $error("correlation out of range");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_grade_ff != 2'd3)
      else $error("grade code unused");

   // issuing a result clears the sums and raises valid
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GRADE && (!rsp_valid_ff || rsp_tready))
      |=> (sum_w_ff == '0 && sum_xx_ff == '0 && rsp_valid_ff && state_ff == ST_IDLE))
      else $error("sums not cleared after result");

   // the shift-add unit consumes one multiplier bit a cycle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL && mplier_ff != '0)
      |=> (state_ff == ST_MUL && mplier_ff == ($past(mplier_ff) >> 1)))
      else $error("multiplier step lost");

endmodule

// File: bench/tb_top.sv
// Self-checking bench for histogram_correlation_check_core.
// Streams histogram cells, predicts each graded correlation in the bench and
// compares correlation, grade and total entries. Depends on hcc_pkg and the core.
`timescale 1ns / 1ps

module tb_top;
   import hcc_pkg::*;

   localparam int IDLE_LIMIT = 20000;   // cycles with no transaction before giving up
   localparam int DRAIN_WAIT = 16;      // lets a cell still in the core finish, with margin

   typedef struct packed {
      logic signed [CORR_BITS-1:0]  corr;
      logic [GRADE_BITS-1:0]        grade;
      logic [WEIGHT_BITS-1:0]       total;
   } verdict_type;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [31:0]              req_tdata;
   logic                     req_tlast;
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [55:0]              rsp_tdata;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;

   // bench copy of the core's registers and running sums
   bit [BIN_BITS-1:0]          x_first, x_final;
   bit signed [CORR_BITS-1:0]  green_floor, red_ceiling;
   bit [WEIGHT_BITS-1:0]       acc_n;
   bit [SUM1_BITS-1:0]         acc_x, acc_y;
   bit [SUM2_BITS-1:0]         acc_xx, acc_yy, acc_xy;

   verdict_type verdict_q[$];
   int       fails;
   int       cells_sent;
   int       verdicts_seen;
   int       hold_cycles;     // long receiver hold-off, counted down by the receiver
   bit       no_gaps;         // suppress idling on both sides
   int       idle_count;

   histogram_correlation_check_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Spread n*sq - s^2 in wide arithmetic; zero marks a nonpositive spread.
   function automatic bit [255:0] spread_of(bit [255:0] n, bit [255:0] s, bit [255:0] sq);
      bit [255:0] p;
      bit [255:0] q;
      p = n * sq;
      q = s * s;
      if (p <= q) begin
         return '0;
      end
      return p - q;
   endfunction

   // Weighted Pearson correlation in Q1.14, magnitude rounded half away from zero.
   function automatic bit signed [CORR_BITS-1:0] pearson_q14();
      bit [255:0] a, b, ab, p, q, c, rhs, lhs, mq;
      bit         neg;
      int unsigned lo, hi, mid;
      int          mag;
      a = spread_of(256'(acc_n), 256'(acc_x), 256'(acc_xx));
      b = spread_of(256'(acc_n), 256'(acc_y), 256'(acc_yy));
      if (a == 0 || b == 0) begin
         return '0;
      end
      ab = a * b;
      p = 256'(acc_n) * 256'(acc_xy);
      q = 256'(acc_x) * 256'(acc_y);
      neg = p < q;
      c = neg ? q - p : p - q;
      rhs = (c * c) << (2 * FRAC_BITS + 2);
      // largest search value whose square times A*B stays within rhs
      lo = 0;
      hi = 1 << (FRAC_BITS + 1);
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         mq = 256'(mid) * 256'(mid);
         lhs = mq * ab;
         if (lhs <= rhs) begin
            lo = mid;
         end else begin
            hi = mid - 1;
         end
      end
      mag = int'((lo + 1) >> 1);
      return neg ? CORR_BITS'(-mag) : CORR_BITS'(mag);
   endfunction

   // Fold one accepted cell into the sums; on the last cell queue the graded result.
   task automatic fold_cell(bit [31:0] data, bit last);
      bit [SUM2_BITS-1:0] x, y, w;
      verdict_type        v;
      x = SUM2_BITS'(data[7:0]);
      y = SUM2_BITS'(data[15:8]);
      w = SUM2_BITS'(data[31:16]);
      if (x_first > x_final || (x >= x_first && x <= x_final)) begin
         acc_n  += WEIGHT_BITS'(w);
         acc_x  += SUM1_BITS'(w * x);
         acc_y  += SUM1_BITS'(w * y);
         acc_xx += w * x * x;
         acc_yy += w * y * y;
         acc_xy += w * x * y;
      end
      if (last) begin
         v.corr  = pearson_q14();
         v.total = acc_n;
         if (v.corr >= green_floor) begin
            v.grade = GRADE_GREEN;
         end else if (v.corr > red_ceiling) begin
            v.grade = GRADE_YELLOW;
         end else begin
            v.grade = GRADE_RED;
         end
         verdict_q.push_back(v);
         {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
      end
   endtask

   // Track every transaction at the rising edge: predictor, result check, watchdog.
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         x_first = 8'd1;
         x_final = 8'd0;
         green_floor = 16'sd14746;
         red_ceiling = 16'sd8192;
         {acc_n, acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
         idle_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RANGE_START: x_first = csr_data[7:0];
               CSR_RANGE_END:   x_final = csr_data[7:0];
               CSR_GREEN_MIN:   green_floor = csr_data;
               CSR_RED_MIN:     red_ceiling = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            fold_cell(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            verdicts_seen++;
            if (verdict_q.size() == 0) begin
               fails++;
               $display("%0t: unexpected result %h", $time, rsp_tdata);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_tdata[15:0] !== want.corr) begin
                  fails++;
                  $display("%0t: correlation expected %0d actual %0d", $time,
                           want.corr, $signed(rsp_tdata[15:0]));
               end
               if (rsp_tdata[17:16] !== want.grade) begin
                  fails++;
                  $display("%0t: grade expected %0d actual %0d", $time,
                           want.grade, rsp_tdata[17:16]);
               end
               if (rsp_tdata[49:18] !== want.total) begin
                  fails++;
                  $display("%0t: total_entries expected %0d actual %0d", $time,
                           want.total, rsp_tdata[49:18]);
               end
            end
         end
         // watchdog: count cycles in which no channel moves a transaction
         if ((csr_valid && csr_ready) || (req_tvalid && req_tready) ||
             (rsp_tvalid && rsp_tready)) begin
            idle_count = 0;
         end else begin
            idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
               $display("watchdog expired at %0t", $time);
               $display("tb_top NOT OK");
               $finish;
            end
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   // Receiver: stall at random; honour a requested long hold-off.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_tready = 1'b0;
            stall_left--;
         end else begin
            rsp_tready = 1'b1;
            if ($urandom_range(0, 9) < 3) begin
               stall_left = gap_len();
            end
         end
      end
   end

   // Offer one cell; returns at the falling edge after acceptance with valid still high.
   task automatic send_cell(bit [7:0] x, bit [7:0] y, bit [15:0] cnt, bit last);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {cnt, y, x};
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      cells_sent++;
   endtask

   task automatic stop_cells();
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
   endtask

   // Hold until every result is back and the core has settled.
   task automatic drain();
      stop_cells();
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_config(int first, int final_x, int green, int red);
      csr_write(CSR_RANGE_START, CSR_DATA_BITS'(first));
      csr_write(CSR_RANGE_END, CSR_DATA_BITS'(final_x));
      csr_write(CSR_GREEN_MIN, CSR_DATA_BITS'(green));
      csr_write(CSR_RED_MIN, CSR_DATA_BITS'(red));
   endtask

   // One histogram of random content; shape picks how y follows x.
   task automatic send_histogram(int len);
      int shape, i;
      bit [7:0] x, y;
      bit [15:0] cnt;
      shape = $urandom_range(0, 4);
      for (i = 0; i < len; i++) begin
         x = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         case (shape)
            0: y = x;
            1: y = 8'(255 - x);
            2: y = 8'(x + $urandom_range(0, 15));
            3: y = 8'($urandom_range(120, 123));
            default: y = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 9))
            0: cnt = 16'hFFFF;
            1: cnt = 16'd0;
            2, 3: cnt = 16'($urandom);
            default: cnt = 16'($urandom_range(1, 40));
         endcase
         send_cell(x, y, cnt, i == len - 1);
      end
   endtask

   // Extremes of the fields and the special cases, at reset settings.
   task automatic test_directed();
      send_cell(8'd1, 8'd1, 16'd0, 1'b1);          // empty histogram
      send_cell(8'd1, 8'd1, 16'd5, 1'b0);          // perfect positive line
      send_cell(8'd2, 8'd2, 16'd5, 1'b0);
      send_cell(8'd255, 8'd255, 16'hFFFF, 1'b1);
      send_cell(8'd1, 8'd255, 16'd3, 1'b0);        // perfect negative line
      send_cell(8'd255, 8'd1, 16'd3, 1'b1);
      send_cell(8'd7, 8'd9, 16'd4, 1'b0);          // constant x: zero spread
      send_cell(8'd7, 8'd30, 16'd4, 1'b1);
      send_cell(8'd0, 8'd0, 16'd2, 1'b0);          // index zero
      send_cell(8'd3, 8'd200, 16'd1, 1'b0);
      send_cell(8'd128, 8'd17, 16'h8000, 1'b1);
      send_cell(8'd42, 8'd42, 16'hFFFF, 1'b1);      // single cell
      drain();
   endtask

   // Range selection and threshold extremes, each register at its limits.
   task automatic test_settings();
      int k;
      int first_v[6] = '{10, 0, 255, 200, 50, 1};
      int final_v[6] = '{20, 255, 255, 100, 50, 0};
      int green_v[6] = '{-16384, 16384, 0, -100, 8192, 14746};
      int red_v[6]   = '{16384, -16384, 0, 100, 8192, 8192};
      for (k = 0; k < 6; k++) begin
         set_config(first_v[k], final_v[k], green_v[k], red_v[k]);
         send_histogram(4);
         send_histogram(2);
         send_cell(8'(first_v[k]), 8'd5, 16'd9, 1'b0);
         send_cell(8'(final_v[k]), 8'd60, 16'd9, 1'b1);
         drain();
      end
   endtask

   // Random histograms over several random settings, some with no idling.
   task automatic test_random();
      int phase, target;
      for (phase = 0; phase < 10; phase++) begin
         no_gaps = (phase % 4 == 3);
         if ($urandom_range(0, 3) == 0) begin
            set_config(1, 0, $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
         end else begin
            set_config($urandom_range(0, 255), $urandom_range(0, 255),
                       $urandom_range(0, 32768) - 16384, $urandom_range(0, 32768) - 16384);
         end
         target = cells_sent + 100;
         while (cells_sent < target) begin
            send_histogram(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                        : $urandom_range(1, 10));
         end
         drain();
      end
      no_gaps = 1'b0;
   endtask

   // Receiver holds off while cells keep coming, so the core stalls its input.
   task automatic test_backpressure();
      int k;
      @(posedge clock);
      hold_cycles = 4000;
      @(negedge clock);
      for (k = 0; k < 8; k++) begin
         send_histogram($urandom_range(1, 5));
      end
      drain();
   endtask

   // Sender pauses until every result is back, then resumes.
   task automatic test_pause();
      int k;
      for (k = 0; k < 4; k++) begin
         send_histogram($urandom_range(2, 6));
         drain();
      end
   endtask

   initial begin
      fails = 0;
      cells_sent = 0;
      verdicts_seen = 0;
      hold_cycles = 0;
      no_gaps = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_RANGE_START;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_directed();
      test_settings();
      test_random();
      test_backpressure();
      test_pause();

      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d cells and %0d graded histograms", cells_sent, verdicts_seen);
      $display("across range, threshold, stall and pause scenarios");
      if (fails == 0 && verdict_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/hcc_pkg.sv
sv/histogram_correlation_check_core.sv
bench/tb_top.sv
